FILE: src/glos_pkg.sv
// ----------------------------------------------------------------------------
// glos_pkg: shared types and constants for the grid line-of-sight core
// Payload structs, queue entry layout, command codes and default sizes.
// ----------------------------------------------------------------------------
package glos_pkg;

	// Coordinate field width and signed cell width used during a walk
	localparam int COORD_W = 6;
	localparam int CELL_W  = COORD_W + 1;
	localparam int ERR_W   = COORD_W + 1;

	// Default grid size
	localparam int GRID_W_DEFAULT = 64;
	localparam int GRID_H_DEFAULT = 64;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Input word
	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] from_x;
		logic [COORD_W-1:0] from_y;
		logic [COORD_W-1:0] to_x;
		logic [COORD_W-1:0] to_y;
		logic               blocked_value;
	} glos_in_t;

	// Result word
	typedef struct packed {
		logic               visible;
		logic [COORD_W-1:0] last_x;
		logic [COORD_W-1:0] last_y;
		logic               last_valid;
	} glos_out_t;

	// Classified operation held in the queue
	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic               blk;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic               sx_neg;
		logic               sy_neg;
		logic               xmajor;
		logic               zero_len;
	} glos_op_t;

	// Queue head seen by the back part
	typedef struct packed {
		logic     valid;
		glos_op_t op;
	} glos_head_t;

	// Status from the back part to the front part
	typedef struct packed {
		logic clearing;
		logic pop;
	} glos_back_stat_t;

endpackage

FILE: src/glos_ram.sv
// ----------------------------------------------------------------------------
// glos_ram: generic RAM, one write port and two registered read ports
// Write and read addresses are independent; read data is registered and appears in the next cycle.
// ----------------------------------------------------------------------------
module glos_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read two with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: src/glos_front.sv
// ----------------------------------------------------------------------------
// glos_front: input side of the line-of-sight core
// Accepts words, works out deltas, directions and major axis, and holds the
// classified operations in a short queue for the back part.
// ----------------------------------------------------------------------------
module glos_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  glos_pkg::glos_in_t       request,
	input  glos_pkg::glos_back_stat_t stat,
	output glos_pkg::glos_head_t     head
);

	import glos_pkg::*;

	glos_op_t            op_new;
	glos_op_t            op_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                push_ok;
	logic                pop_ok;

	// Classify the incoming word
	always_comb begin
		op_new.cmd      = request.cmd;
		op_new.x0       = request.from_x;
		op_new.y0       = request.from_y;
		op_new.x1       = request.to_x;
		op_new.y1       = request.to_y;
		op_new.blk      = request.blocked_value;
		op_new.sx_neg   = !(request.to_x > request.from_x);
		op_new.sy_neg   = !(request.to_y > request.from_y);
		op_new.dx       = op_new.sx_neg ? (request.from_x - request.to_x)
		                                : (request.to_x - request.from_x);
		op_new.dy       = op_new.sy_neg ? (request.from_y - request.to_y)
		                                : (request.to_y - request.from_y);
		op_new.xmajor   = (op_new.dx >= op_new.dy);
		op_new.zero_len = (request.from_x == request.to_x) &&
		                  (request.from_y == request.to_y);
	end

	// Hold off input while the queue is full or the grid is being cleared
	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH)) || stat.clearing;
	assign push_ok = push && !full;
	assign pop_ok  = stat.pop && (cnt_q != '0);

	// Store the classified word
	always_ff @(posedge clk) begin
		if (push_ok) begin
			op_q[wr_ptr_q] <= op_new;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Present the oldest operation
	assign head.valid = (cnt_q != '0);
	assign head.op    = op_q[rd_ptr_q];

endmodule

FILE: src/glos_back.sv
// ----------------------------------------------------------------------------
// glos_back: execution side of the line-of-sight core
// Owns the occupancy RAM and its clearing pass, applies cell writes and walks
// query lines one step per cycle, with lookups checked in the cycle after they are issued.
// ----------------------------------------------------------------------------
module glos_back #(
	parameter int GRID_W = glos_pkg::GRID_W_DEFAULT,
	parameter int GRID_H = glos_pkg::GRID_H_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  glos_pkg::glos_head_t      head,
	output glos_pkg::glos_back_stat_t stat,
	input  logic                      pop,
	output logic                      empty,
	output glos_pkg::glos_out_t       result
);

	import glos_pkg::*;

	localparam int DEPTH = GRID_W * GRID_H;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(GRID_W);
	localparam logic [CELL_W-1:0] MINUS_ONE = '1;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_WALK   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	// Cell inside the grid (sign bit clear and below the limits)
	function automatic logic in_grid(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y);
		in_grid = !x[CELL_W-1] && !y[CELL_W-1] &&
		          ({26'd0, x[COORD_W-1:0]} < 32'(GRID_W)) &&
		          ({26'd0, y[COORD_W-1:0]} < 32'(GRID_H));
	endfunction

	// Linear address of an in-grid cell
	function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		cell_addr = AW'(x) + AW'(y) * ROW_STRIDE;
	endfunction

	logic [1:0]          state_q;
	logic [AW-1:0]       clr_q;
	glos_op_t            op;
	logic                q_pop;
	logic                pop_ok;

	// Walk registers
	logic                walk_q;
	logic [COORD_W-1:0]  cx_q, cy_q, x1_q, y1_q, dx_q, dy_q;
	logic [ERR_W-1:0]    err_q;
	logic                sx_neg_q, sy_neg_q, xmajor_q;

	// Working result
	logic                vis_q, lv_q;
	logic [COORD_W-1:0]  lx_q, ly_q;
	glos_out_t           res_q;
	logic                res_valid_q;

	// Check stage
	logic                ev_valid_s1, ev_last_s1, ev_pair_s1;
	logic                ev_need_a_s1, ev_need_b_s1, ev_oob_a_s1, ev_oob_b_s1;
	logic                ev_fail_rec_s1;
	logic [COORD_W-1:0]  ev_pass_x_s1, ev_pass_y_s1, ev_fail_x_s1, ev_fail_y_s1;

	// Step logic
	logic [CELL_W-1:0]   ox, oy, cx7, cy7, xo, yo;
	logic [COORD_W-1:0]  cx_nx, cy_nx, cx_step, cy_step;
	logic [ERR_W-1:0]    e1, e2;
	logic                carry;
	logic [CELL_W-1:0]   ax, ay, bx, by;
	logic                pair, need_a, need_b, step_last, fail_rec;
	logic [CELL_W-1:0]   pass_x7, pass_y7;
	logic                issue_en, fail_now, blk_a, blk_b, step_fail;

	// RAM ports
	logic                ram_we, ram_wdata, rd_a, rd_b;
	logic [AW-1:0]       ram_waddr, ram_raddr_a, ram_raddr_b;
	logic                wr_item;

	assign op     = head.op;
	assign pop_ok = pop && res_valid_q;
	assign q_pop  = (state_q == ST_IDLE) && head.valid;

	// Compute one walk step from the current position and error term
	always_comb begin
		ox      = sx_neg_q ? MINUS_ONE : '0;
		oy      = sy_neg_q ? MINUS_ONE : '0;
		cx7     = {1'b0, cx_q};
		cy7     = {1'b0, cy_q};
		xo      = cx7 + ox;
		yo      = cy7 + oy;
		cx_nx   = sx_neg_q ? (cx_q - 1'b1) : (cx_q + 1'b1);
		cy_nx   = sy_neg_q ? (cy_q - 1'b1) : (cy_q + 1'b1);
		if (xmajor_q) begin
			e1        = err_q + {1'b0, dy_q};
			carry     = (e1 >= {1'b0, dx_q});
			e2        = carry ? (e1 - {1'b0, dx_q}) : e1;
			cx_step   = cx_nx;
			cy_step   = carry ? cy_nx : cy_q;
			step_last = (cx_nx == x1_q);
			fail_rec  = 1'b0;
			pass_x7   = xo;
			pass_y7   = {1'b0, cy_step} + oy;
			if (dy_q == '0) begin
				pair   = 1'b1;
				ax     = xo;
				ay     = cy7;
				bx     = xo;
				by     = cy7 + MINUS_ONE;
				need_a = 1'b1;
				need_b = 1'b1;
			end else begin
				pair   = 1'b0;
				ax     = xo;
				ay     = yo;
				bx     = xo;
				by     = {1'b0, cy_step} + oy;
				need_a = carry;
				need_b = (e2 != '0);
			end
		end else begin
			e1        = err_q + {1'b0, dx_q};
			carry     = (e1 >= {1'b0, dy_q});
			e2        = carry ? (e1 - {1'b0, dy_q}) : e1;
			cx_step   = carry ? cx_nx : cx_q;
			cy_step   = cy_nx;
			step_last = (cy_nx == y1_q);
			fail_rec  = 1'b1;
			pass_x7   = {1'b0, cx_step} + ox;
			pass_y7   = yo;
			if (dx_q == '0) begin
				pair   = 1'b1;
				ax     = cx7;
				ay     = yo;
				bx     = cx7 + MINUS_ONE;
				by     = yo;
				need_a = 1'b1;
				need_b = 1'b1;
			end else begin
				pair   = 1'b0;
				ax     = xo;
				ay     = yo;
				bx     = {1'b0, cx_step} + ox;
				by     = yo;
				need_a = carry;
				need_b = (e2 != '0);
			end
		end
	end

	// Check the step issued last cycle against the RAM data
	always_comb begin
		blk_a     = ev_oob_a_s1 || rd_a;
		blk_b     = ev_oob_b_s1 || rd_b;
		step_fail = ev_pair_s1 ? (blk_a && blk_b)
		                       : ((ev_need_a_s1 && blk_a) || (ev_need_b_s1 && blk_b));
		fail_now  = ev_valid_s1 && step_fail;
		issue_en  = (state_q == ST_WALK) && walk_q && !fail_now;
	end

	// Drive the RAM: clearing sweep, cell write, or two step lookups
	always_comb begin
		wr_item     = q_pop && (op.cmd == CMD_WRITE) &&
		              in_grid({1'b0, op.x0}, {1'b0, op.y0});
		ram_we      = (state_q == ST_CLEAR) || wr_item;
		ram_waddr   = (state_q == ST_CLEAR) ? clr_q : cell_addr(op.x0, op.y0);
		ram_wdata   = (state_q == ST_CLEAR) ? 1'b0 : op.blk;
		ram_raddr_a = cell_addr(ax[COORD_W-1:0], ay[COORD_W-1:0]);
		ram_raddr_b = cell_addr(bx[COORD_W-1:0], by[COORD_W-1:0]);
	end

	glos_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_occ (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Load the step into the check stage
	always_ff @(posedge clk) begin
		if (issue_en) begin
			ev_last_s1     <= step_last;
			ev_pair_s1     <= pair;
			ev_need_a_s1   <= need_a;
			ev_need_b_s1   <= need_b;
			ev_oob_a_s1    <= !in_grid(ax, ay);
			ev_oob_b_s1    <= !in_grid(bx, by);
			ev_fail_rec_s1 <= fail_rec;
			ev_pass_x_s1   <= pass_x7[COORD_W-1:0];
			ev_pass_y_s1   <= pass_y7[COORD_W-1:0];
			ev_fail_x_s1   <= xo[COORD_W-1:0];
			ev_fail_y_s1   <= yo[COORD_W-1:0];
		end
	end

	// Load a new query or advance the walk position
	always_ff @(posedge clk) begin
		if (q_pop && (op.cmd == CMD_QUERY)) begin
			cx_q     <= op.x0;
			cy_q     <= op.y0;
			x1_q     <= op.x1;
			y1_q     <= op.y1;
			dx_q     <= op.dx;
			dy_q     <= op.dy;
			sx_neg_q <= op.sx_neg;
			sy_neg_q <= op.sy_neg;
			xmajor_q <= op.xmajor;
			err_q    <= '0;
		end else if (issue_en) begin
			cx_q  <= cx_step;
			cy_q  <= cy_step;
			err_q <= e2;
		end
	end

	// Sequence clearing, idle, walk and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			walk_q      <= 1'b0;
			ev_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			vis_q       <= 1'b0;
			lv_q        <= 1'b0;
			lx_q        <= '0;
			ly_q        <= '0;
		end else begin
			ev_valid_s1 <= issue_en;
			if (issue_en && step_last) begin
				walk_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop && (op.cmd == CMD_QUERY)) begin
						vis_q <= 1'b1;
						lv_q  <= 1'b0;
						lx_q  <= '0;
						ly_q  <= '0;
						if (op.zero_len) begin
							state_q <= ST_FINISH;
						end else begin
							walk_q  <= 1'b1;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (fail_now) begin
						vis_q   <= 1'b0;
						walk_q  <= 1'b0;
						state_q <= ST_FINISH;
						if (ev_fail_rec_s1) begin
							lv_q <= 1'b1;
							lx_q <= ev_fail_x_s1;
							ly_q <= ev_fail_y_s1;
						end
					end else if (ev_valid_s1) begin
						lv_q <= 1'b1;
						lx_q <= ev_pass_x_s1;
						ly_q <= ev_pass_y_s1;
						if (ev_last_s1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (!res_valid_q || pop_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_FINISH) && (!res_valid_q || pop_ok)) begin
				res_valid_q <= 1'b1;
			end else if (pop_ok) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Capture the finished result
	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && (!res_valid_q || pop_ok)) begin
			res_q.visible    <= vis_q;
			res_q.last_x     <= lx_q;
			res_q.last_y     <= ly_q;
			res_q.last_valid <= lv_q;
		end
	end

	assign result        = res_q;
	assign empty         = !res_valid_q;
	assign stat.clearing = (state_q == ST_CLEAR);
	assign stat.pop      = q_pop;

	// Lookups are checked only while a walk is in progress
	a_eval_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_s1 |-> (state_q == ST_WALK))
		else $error("step check outside of a walk");

	// Nothing leaves the queue during the clearing sweep
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !q_pop)
		else $error("queue popped while clearing");

	// A result shows up only out of the finish state
	a_res_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result appeared without a finished query");

	// The error term stays below the major-axis length while walking
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && walk_q) |->
		(xmajor_q ? (err_q < {1'b0, dx_q}) : (err_q < {1'b0, dy_q})))
		else $error("error term out of range");

endmodule

FILE: src/grid_line_of_sight_core.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight_core: occupancy grid with line-of-sight queries
// After reset the core clears its GRID_W*GRID_H cell occupancy RAM, one cell
// per cycle, and holds full high until that sweep is done. A write word sets
// one cell blocked or free in the execution side. A query word walks the line
// between two cell corners at one step per cycle, set by the two-read-port
// occupancy RAM whose registered data is checked in the cycle after each step
// is issued; a query of max(|dx|,|dy|) steps stops early at the first blocked
// step. A two-entry queue lets new words come in while a walk runs, and a
// finished result waits in an output register until it is popped.
// ----------------------------------------------------------------------------
module grid_line_of_sight_core #(
	parameter int GRID_W = glos_pkg::GRID_W_DEFAULT,
	parameter int GRID_H = glos_pkg::GRID_H_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  glos_pkg::glos_in_t  request,
	output logic                empty,
	input  logic                pop,
	output glos_pkg::glos_out_t result
);

	import glos_pkg::*;

	glos_head_t      head;
	glos_back_stat_t stat;

	// Accept and classify words
	glos_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.stat    (stat),
		.head    (head)
	);

	// Execute writes and walks
	glos_back #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for grid_line_of_sight_core
// Drives cell writes and line-of-sight queries through the input queue port
// and predicts every query result from its own copy of the occupancy grid.
// Popped results are compared field by field with the oldest prediction.
// Runs directed corner cases, a long receiver hold-off that fills the core,
// then random words under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import glos_pkg::*;

	localparam int GRID_W       = GRID_W_DEFAULT;
	localparam int GRID_H       = GRID_H_DEFAULT;
	localparam int LIMIT_CYCLES = 800000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_REPORTS  = 50;

	// Query word paired with the result it should produce
	typedef struct {
		glos_in_t  req;
		glos_out_t res;
	} sight_exp_t;

	logic      clk;
	logic      arst_n  = 1'b0;
	logic      push    = 1'b0;
	logic      full;
	glos_in_t  request = '0;
	logic      empty;
	logic      pop     = 1'b0;
	glos_out_t result;

	bit         occ_map [GRID_W*GRID_H];
	sight_exp_t expected_sight [$];
	int         mismatch_count = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         hold_cycles    = 0;

	grid_line_of_sight_core #(
		.GRID_W(GRID_W),
		.GRID_H(GRID_H)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// End the run if the core hangs
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("Verification failed");
		$finish;
	end

	// Cells off the grid count as blocked
	function automatic bit cell_blocked(int x, int y);
		if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H)
			return 1'b1;
		return occ_map[x + y * GRID_W];
	endfunction

	// Walk the corner-to-corner line and work out visibility and last cell
	function automatic glos_out_t sight_line(glos_in_t w);
		int        x0, y0, x1, y1, dx, dy, sx, sy, ox, oy, cx, cy, err, lx, ly;
		bit        seen, vis;
		glos_out_t r;
		x0 = int'(w.from_x);
		y0 = int'(w.from_y);
		x1 = int'(w.to_x);
		y1 = int'(w.to_y);
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y1 - y0 : y0 - y1;
		sx = (x1 > x0) ? 1 : -1;
		sy = (y1 > y0) ? 1 : -1;
		ox = (sx > 0) ? 0 : -1;
		oy = (sy > 0) ? 0 : -1;
		cx = x0;
		cy = y0;
		err = 0;
		lx = 0;
		ly = 0;
		seen = 1'b0;
		vis = 1'b1;
		if (dx >= dy) begin
			// x-major: record a cell once it passes its tests
			while (vis && cx != x1) begin
				err += dy;
				if (err >= dx) begin
					if (cell_blocked(cx + ox, cy + oy))
						vis = 1'b0;
					else begin
						cy += sy;
						err -= dx;
					end
				end
				if (vis && err != 0 && cell_blocked(cx + ox, cy + oy))
					vis = 1'b0;
				if (vis && dy == 0 && cell_blocked(cx + ox, cy)
						&& cell_blocked(cx + ox, cy - 1))
					vis = 1'b0;
				if (vis) begin
					lx = cx + ox;
					ly = cy + oy;
					seen = 1'b1;
					cx += sx;
				end
			end
		end else begin
			// y-major: record the current cell at the top of each step
			while (vis && cy != y1) begin
				lx = cx + ox;
				ly = cy + oy;
				seen = 1'b1;
				err += dx;
				if (err >= dy) begin
					if (cell_blocked(cx + ox, cy + oy))
						vis = 1'b0;
					else begin
						cx += sx;
						err -= dy;
					end
				end
				if (vis && err != 0 && cell_blocked(cx + ox, cy + oy))
					vis = 1'b0;
				if (vis && dx == 0 && cell_blocked(cx, cy + oy)
						&& cell_blocked(cx - 1, cy + oy))
					vis = 1'b0;
				if (vis) begin
					lx = cx + ox;
					ly = cy + oy;
					cy += sy;
				end
			end
		end
		r.visible    = vis;
		r.last_valid = seen;
		r.last_x     = seen ? lx[COORD_W-1:0] : '0;
		r.last_y     = seen ? ly[COORD_W-1:0] : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t ERROR %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input glos_in_t req, input int got,
			input int want);
		if (got != want)
			report_mismatch($sformatf("%s for query (%0d,%0d)->(%0d,%0d): got %0d, expected %0d",
				name, req.from_x, req.from_y, req.to_x, req.to_y, got, want));
	endtask

	// Track accepted words and check each popped result
	always @(posedge clk) begin : track_words
		sight_exp_t e;
		if (arst_n) begin
			if (push && !full) begin
				if (request.cmd == CMD_WRITE)
					occ_map[int'(request.from_x) + int'(request.from_y) * GRID_W] =
						request.blocked_value;
				else begin
					e.req = request;
					e.res = sight_line(request);
					expected_sight = {expected_sight, e};
				end
			end
			if (pop && !empty) begin
				if (expected_sight.size() == 0)
					report_mismatch($sformatf("result word with nothing pending: %h", result));
				else begin
					e = expected_sight.pop_front();
					compare_field("visible", e.req, int'(result.visible),
						int'(e.res.visible));
					compare_field("last_x", e.req, int'(result.last_x), int'(e.res.last_x));
					compare_field("last_y", e.req, int'(result.last_y), int'(e.res.last_y));
					compare_field("last_valid", e.req, int'(result.last_valid),
						int'(e.res.last_valid));
				end
			end
		end
	end

	// Drive pop: hold off while a hold is pending, else stall at random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			pop <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else
			pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offer one word, idling first at random, and wait until it is taken
	task automatic send_word(input glos_in_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		request <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Stop sending and let every pending result come out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_sight.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic glos_in_t mk_write(int x, int y, bit blk);
		glos_in_t w;
		w.cmd           = CMD_WRITE;
		w.from_x        = COORD_W'(x);
		w.from_y        = COORD_W'(y);
		w.to_x          = COORD_W'($urandom_range(63));
		w.to_y          = COORD_W'($urandom_range(63));
		w.blocked_value = blk;
		return w;
	endfunction

	function automatic glos_in_t mk_query(int fx, int fy, int tx, int ty);
		glos_in_t w;
		w.cmd           = CMD_QUERY;
		w.from_x        = COORD_W'(fx);
		w.from_y        = COORD_W'(fy);
		w.to_x          = COORD_W'(tx);
		w.to_y          = COORD_W'(ty);
		w.blocked_value = 1'($urandom_range(1));
		return w;
	endfunction

	// Mostly short lines and writes inside a 16x16 window so that blocked
	// cells get hit, plus axis-aligned, full-range and tiny queries
	function automatic glos_in_t random_word(int bx, int by);
		glos_in_t w;
		int       kind;
		w = mk_query(bx + $urandom_range(15), by + $urandom_range(15),
			$urandom_range(63), $urandom_range(63));
		kind = $urandom_range(99);
		if (kind < 30) begin
			w.cmd           = CMD_WRITE;
			w.blocked_value = ($urandom_range(99) < 40);
		end else if (kind < 60) begin
			w.to_x = COORD_W'(bx + int'($urandom_range(15)));
			w.to_y = COORD_W'(by + int'($urandom_range(15)));
		end else if (kind < 75) begin
			if ($urandom_range(1))
				w.to_y = w.from_y;
			else
				w.to_x = w.from_x;
		end else if (kind < 85) begin
			w.from_x = COORD_W'($urandom_range(63));
			w.from_y = COORD_W'($urandom_range(63));
		end else begin
			w.to_x = COORD_W'(int'(w.from_x) + int'($urandom_range(2)) - 1);
			w.to_y = COORD_W'(int'(w.from_y) + int'($urandom_range(2)) - 1);
		end
		return w;
	endfunction

	// Corners, zero length, edge rows and columns, blocked and cleared cells
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_word(mk_query(0, 0, 0, 0));
		send_word(mk_query(63, 63, 63, 63));
		send_word(mk_query(0, 0, 63, 63));
		send_word(mk_query(63, 63, 0, 0));
		send_word(mk_query(0, 0, 63, 0));
		send_word(mk_query(1, 1, 0, 0));
		send_word(mk_query(0, 63, 0, 0));
		send_word(mk_write(10, 0, 1'b1));
		send_word(mk_query(0, 0, 63, 0));
		send_word(mk_write(0, 20, 1'b1));
		send_word(mk_query(0, 0, 0, 63));
		send_word(mk_write(20, 20, 1'b1));
		send_word(mk_query(0, 0, 40, 40));
		send_word(mk_query(0, 0, 40, 1));
		send_word(mk_query(5, 0, 7, 40));
		send_word(mk_write(20, 20, 1'b0));
		send_word(mk_query(0, 0, 40, 40));
		send_word(mk_write(0, 0, 1'b1));
		send_word(mk_query(0, 0, 1, 1));
		send_word(mk_write(63, 63, 1'b1));
		send_word(mk_query(63, 63, 0, 0));
		send_word(mk_query(0, 62, 63, 63));
		send_word(mk_write(63, 63, 1'b0));
		send_word(mk_write(0, 0, 1'b0));
		drain();
	endtask

	// Hold pop low for a long stretch while long queries keep coming
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 400;
		for (int i = 0; i < 12; i++)
			send_word(mk_query(0, $urandom_range(63), 63, $urandom_range(63)));
		drain();
	endtask

	task automatic test_random(input int n_words, input int idle_pct, input int stall_pct);
		int bx, by;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		bx = 0;
		by = 0;
		for (int i = 0; i < n_words; i++) begin
			// move the window now and then, often onto an edge
			if (i % 40 == 0) begin
				bx = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 48 : 0)
					: $urandom_range(48);
				by = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 48 : 0)
					: $urandom_range(48);
			end
			send_word(random_word(bx, by));
		end
		drain();
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(230, 0, 0);
		test_random(230, 67, 0);
		test_random(230, 0, 67);
		test_random(230, 34, 34);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: grid_line_of_sight_core.f
src/glos_pkg.sv
src/glos_ram.sv
src/glos_front.sv
src/glos_back.sv
src/grid_line_of_sight_core.sv
tb/testbench.sv
